>>> src/sha_pkg.sv
package sha_pkg;

   localparam int unsigned BLOCK_BYTES = 64;
   localparam int unsigned ROUNDS      = 64;
   localparam logic [7:0]  PAD_BYTE    = 8'h80;
   localparam logic [5:0]  LEN_POS     = 6'd56;

   typedef enum logic {
      FUNC_ABSORB = 1'b0,
      FUNC_FINISH = 1'b1
   } func_type;

   // Controller to datapath
   typedef struct packed {
      logic       load_byte;   // write byte into the block buffer
      logic [7:0] byte_val;
      logic       count_byte;  // bump message length
      logic       latch_len;   // capture bit length for the trailer
      logic       start_comp;  // begin a compression
      logic       round_en;    // run one round
      logic       finish_comp; // fold working vars into chain
      logic       reset_msg;   // return chain, fill and length to initial values
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [5:0] fill;
      logic       last_round;
      logic [7:0] len_byte;    // trailer byte at the current fill position
   } status_type;

   typedef logic [31:0] word_type;

   function automatic word_type round_k(input logic [5:0] i);
      word_type k;
      case (i)
         6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
         6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
         6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
         6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
         6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
         6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
         6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
         6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
         6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
         6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
         6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
         6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
         default: k = 32'hc67178f2;
      endcase
      return k;
   endfunction

   function automatic word_type init_h(input logic [2:0] i);
      word_type h;
      case (i)
         3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
         3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
         3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
         3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
      endcase
      return h;
   endfunction

endpackage

>>> src/sha_datapath.sv
module sha_datapath
   import sha_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   input  logic [2:0]  out_sel,
   output status_type  stat,
   output word_type    out_word
);

   word_type   chain_ff [8];
   word_type   chain_in [8];
   word_type   vars_ff  [8];
   word_type   vars_in  [8];
   // 16-word schedule window; block bytes land in it big-endian
   word_type   sched_ff [16];
   word_type   sched_in [16];
   logic [5:0]  fill_ff, fill_in;
   logic [5:0]  round_ff, round_in;
   logic [63:0] msg_len_ff, msg_len_in;
   logic [63:0] bit_len_ff;
   logic [7:0]  len_byte;

   word_type w_cur, w_new, s0, s1, t1, t2, ch, maj, sg0, sg1;
   word_type a, e;
   logic [3:0] wi;
   logic [1:0] bi;

   assign a = vars_ff[0];
   assign e = vars_ff[4];
   assign w_cur = sched_ff[0];
   assign sg0 = {sched_ff[1][6:0], sched_ff[1][31:7]} ^ {sched_ff[1][17:0], sched_ff[1][31:18]}
                ^ (sched_ff[1] >> 3);
   assign sg1 = {sched_ff[14][16:0], sched_ff[14][31:17]}
                ^ {sched_ff[14][18:0], sched_ff[14][31:19]} ^ (sched_ff[14] >> 10);
   assign w_new = sched_ff[0] + sg0 + sched_ff[9] + sg1;
   assign s1 = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
   assign ch = (e & vars_ff[5]) ^ (~e & vars_ff[6]);
   assign t1 = vars_ff[7] + s1 + ch + round_k(round_ff) + w_cur;
   assign s0 = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
   assign maj = (a & vars_ff[1]) ^ (a & vars_ff[2]) ^ (vars_ff[1] & vars_ff[2]);
   assign t2 = s0 + maj;
   assign wi = fill_ff[5:2];
   assign bi = fill_ff[1:0];

   always_comb begin
      chain_in   = chain_ff;
      vars_in    = vars_ff;
      sched_in   = sched_ff;
      fill_in    = fill_ff;
      round_in   = round_ff;
      msg_len_in = msg_len_ff;
      // place byte, advance fill
      if (cmd.load_byte) begin
         case (bi)
            2'd0: sched_in[wi][31:24] = cmd.byte_val;
            2'd1: sched_in[wi][23:16] = cmd.byte_val;
            2'd2: sched_in[wi][15:8]  = cmd.byte_val;
            default: sched_in[wi][7:0] = cmd.byte_val;
         endcase
         fill_in = fill_ff + 6'd1;
      end
      if (cmd.count_byte)
         msg_len_in = msg_len_ff + 64'd1;
      if (cmd.start_comp) begin
         vars_in  = chain_ff;
         round_in = '0;
      end
      // one round; shift the schedule window
      if (cmd.round_en) begin
         vars_in[7] = vars_ff[6];
         vars_in[6] = vars_ff[5];
         vars_in[5] = vars_ff[4];
         vars_in[4] = vars_ff[3] + t1;
         vars_in[3] = vars_ff[2];
         vars_in[2] = vars_ff[1];
         vars_in[1] = vars_ff[0];
         vars_in[0] = t1 + t2;
         for (int i = 0; i < 15; i++)
            sched_in[i] = sched_ff[i+1];
         sched_in[15] = w_new;
         round_in = round_ff + 6'd1;
      end
      if (cmd.finish_comp)
         for (int i = 0; i < 8; i++)
            chain_in[i] = chain_ff[i] + vars_ff[i];
      if (cmd.reset_msg) begin
         for (int i = 0; i < 8; i++)
            chain_in[i] = init_h(3'(i));
         fill_in    = '0;
         msg_len_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++)
            chain_ff[i] <= init_h(3'(i));
         fill_ff    <= '0;
         msg_len_ff <= '0;
         round_ff   <= '0;
      end else begin
         chain_ff   <= chain_in;
         fill_ff    <= fill_in;
         msg_len_ff <= msg_len_in;
         round_ff   <= round_in;
      end
      vars_ff  <= vars_in;
      sched_ff <= sched_in;
      if (cmd.latch_len)
         bit_len_ff <= {msg_len_ff[60:0], 3'b000};
   end

   // trailer byte for fill positions 56..63, most significant first
   always_comb begin
      case (fill_ff[2:0])
         3'd0: len_byte = bit_len_ff[63:56];
         3'd1: len_byte = bit_len_ff[55:48];
         3'd2: len_byte = bit_len_ff[47:40];
         3'd3: len_byte = bit_len_ff[39:32];
         3'd4: len_byte = bit_len_ff[31:24];
         3'd5: len_byte = bit_len_ff[23:16];
         3'd6: len_byte = bit_len_ff[15:8];
         default: len_byte = bit_len_ff[7:0];
      endcase
   end

   assign stat = '{fill: fill_ff,
                   last_round: (round_ff == 6'(ROUNDS - 1)),
                   len_byte: len_byte};
   assign out_word = chain_ff[out_sel];

endmodule

>>> src/sha_control.sv
module sha_control
   import sha_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_byte,
   input  logic        req_finish,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [2:0]  out_sel,
   output cmd_type     cmd,
   input  status_type  stat
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_ROUND = 6'b000010,
      ST_FOLD  = 6'b000100,
      ST_PAD   = 6'b001000,
      ST_LEN   = 6'b010000,
      ST_EMIT  = 6'b100000
   } state_type;

   state_type  state_ff, state_in;
   logic       fin_ff, fin_in;     // compression is part of the final padding
   logic       trail_ff, trail_in; // compression holds the length trailer
   logic [2:0] idx_ff, idx_in;
   logic       take;

   assign req_tready = (state_ff == ST_IDLE);
   assign take       = req_tvalid && req_tready;
   assign rsp_tvalid = (state_ff == ST_EMIT);
   assign out_sel    = idx_ff;

   always_comb begin
      state_in = state_ff;
      fin_in   = fin_ff;
      trail_in = trail_ff;
      idx_in   = idx_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               cmd.load_byte = 1'b1;
               trail_in      = 1'b0;
               if (req_finish == FUNC_FINISH) begin
                  cmd.byte_val  = PAD_BYTE;
                  cmd.latch_len = 1'b1;
                  fin_in        = 1'b1;
               end else begin
                  cmd.byte_val   = req_byte;
                  cmd.count_byte = 1'b1;
                  fin_in         = 1'b0;
               end
               if (stat.fill == 6'(BLOCK_BYTES - 1)) begin
                  cmd.start_comp = 1'b1;
                  state_in       = ST_ROUND;
               end else if (req_finish == FUNC_FINISH) begin
                  state_in = (stat.fill + 6'd1 == LEN_POS) ? ST_LEN : ST_PAD;
               end
            end
         end
         ST_ROUND: begin
            cmd.round_en = 1'b1;
            if (stat.last_round)
               state_in = ST_FOLD;
         end
         ST_FOLD: begin
            cmd.finish_comp = 1'b1;
            if (!fin_ff)
               state_in = ST_IDLE;
            else if (!trail_ff)
               state_in = ST_PAD;
            else begin
               // trailer block done
               state_in = ST_EMIT;
               idx_in   = '0;
            end
         end
         ST_PAD: begin
            cmd.load_byte = 1'b1;
            cmd.byte_val  = 8'h00;
            if (stat.fill == 6'(BLOCK_BYTES - 1)) begin
               cmd.start_comp = 1'b1;
               state_in       = ST_ROUND;
            end else if (stat.fill + 6'd1 == LEN_POS)
               state_in = ST_LEN;
         end
         ST_LEN: begin
            cmd.load_byte = 1'b1;
            cmd.byte_val  = stat.len_byte;
            if (stat.fill == 6'(BLOCK_BYTES - 1)) begin
               cmd.start_comp = 1'b1;
               trail_in       = 1'b1;
               state_in       = ST_ROUND;
            end
         end
         ST_EMIT: begin
            if (rsp_tready) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  cmd.reset_msg = 1'b1;
                  state_in      = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fin_ff   <= 1'b0;
         trail_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         fin_ff   <= fin_in;
         trail_ff <= trail_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

>>> src/sha256_message_digest_unit.sv
// SHA-256 over a byte stream. Each transfer carries one message byte or a
// finish command. The 64th byte of a block starts a compression (64 rounds
// on the single shared round unit, then a fold), during which req_tready is
// low, so no byte is taken until it is done; between compressions bytes are
// taken back to back. A finish pads (one pad/length byte at a time, one or
// two compressions) and then returns the eight digest words, word 0 first,
// the last marked by rsp_tlast. The block then starts over with a new message.
module sha256_message_digest_unit
   import sha_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // [7:0] data_byte
   input  logic        req_tuser,  // [0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // [31:0] digest_word, [34:32] word_index, rest zero
   output logic        rsp_tlast   // last_word
);

   cmd_type    cmd;
   status_type stat;
   logic [2:0] out_sel;
   word_type   out_word;

   sha_control u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_byte   (req_tdata),
      .req_finish (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .out_sel    (out_sel),
      .cmd        (cmd),
      .stat       (stat)
   );

   sha_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .out_sel  (out_sel),
      .stat     (stat),
      .out_word (out_word)
   );

   assign rsp_tdata = {5'b00000, out_sel, out_word};
   assign rsp_tlast = (out_sel == 3'd7);

endmodule

>>> tb/sv/testbench.sv
module testbench;
   import sha_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Software SHA-256 of the absorbed byte stream, with a queue of digest words
   class digest_scoreboard;
      logic [31:0] chain[8];
      logic [7:0]  blk[64];
      int unsigned fill;
      logic [63:0] msg_len;
      logic [31:0] pending_word[$];
      logic [2:0]  pending_index[$];
      logic        pending_last[$];
      int unsigned errors;

      function new();
         errors = 0;
         restart();
      endfunction

      function void restart();
         for (int i = 0; i < 8; i++) chain[i] = init_h(3'(i));
         fill = 0;
         msg_len = '0;
      endfunction

      function logic [31:0] ror(logic [31:0] v, int n);
         return (v >> n) | (v << (32 - n));
      endfunction

      function void compress();
         logic [31:0] w[64];
         logic [31:0] r[8];
         logic [31:0] t1, t2, x, y;
         for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
         for (int i = 16; i < 64; i++) begin
            x = w[i-15];
            y = w[i-2];
            w[i] = w[i-16] + (ror(x, 7) ^ ror(x, 18) ^ (x >> 3)) + w[i-7]
                   + (ror(y, 17) ^ ror(y, 19) ^ (y >> 10));
         end
         r = chain;
         for (int i = 0; i < 64; i++) begin
            t1 = r[7] + (ror(r[4], 6) ^ ror(r[4], 11) ^ ror(r[4], 25))
                 + ((r[4] & r[5]) ^ (~r[4] & r[6])) + round_k(6'(i)) + w[i];
            t2 = (ror(r[0], 2) ^ ror(r[0], 13) ^ ror(r[0], 22))
                 + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
            r[7] = r[6]; r[6] = r[5]; r[5] = r[4]; r[4] = r[3] + t1;
            r[3] = r[2]; r[2] = r[1]; r[1] = r[0]; r[0] = t1 + t2;
         end
         for (int i = 0; i < 8; i++) chain[i] += r[i];
      endfunction

      function void put_byte(logic [7:0] b);
         blk[fill] = b;
         fill = (fill + 1) % 64;
         if (fill == 0) compress();
      endfunction

      // Note an accepted request transfer
      function void note_request(func_type f, logic [7:0] b);
         logic [63:0] bits;
         if (f == FUNC_ABSORB) begin
            msg_len++;
            put_byte(b);
            return;
         end
         bits = msg_len << 3;
         put_byte(PAD_BYTE);
         while (fill != LEN_POS) put_byte(8'h00);
         for (int i = 0; i < 8; i++) put_byte(bits[63-8*i -: 8]);
         for (int i = 0; i < 8; i++) begin
            pending_word  = {pending_word, chain[i]};
            pending_index = {pending_index, 3'(i)};
            pending_last  = {pending_last, (i == 7)};
         end
         restart();
      endfunction

      // Check one accepted response transfer against the oldest digest word
      function void check_response(logic [39:0] data, logic last);
         logic [31:0] ew;
         logic [2:0]  ei;
         logic        el;
         if (pending_word.size() == 0) begin
            $error("unexpected response transfer data=%h", data);
            errors++;
            return;
         end
         ew = pending_word.pop_front();
         ei = pending_index.pop_front();
         el = pending_last.pop_front();
         if (data[31:0] !== ew) begin
            $error("digest_word expected %h actual %h", ew, data[31:0]);
            errors++;
         end
         if (data[34:32] !== ei) begin
            $error("word_index expected %0d actual %0d", ei, data[34:32]);
            errors++;
         end
         if (last !== el) begin
            $error("last_word expected %0d actual %0d", el, last);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;

   digest_scoreboard sb = new();
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned quiet_cycles = 0;

   sha256_message_digest_unit uut (.*);

   always #6 clock = ~clock;

   // Note transfers at each edge and count cycles without progress
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_request(func_type'(req_tuser), req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata, rsp_tlast);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= 5000) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // Receiver: stall at random per phase
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Drive one request and hold it until the transfer
   task automatic send_item(func_type f, logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= f;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_message(int unsigned len);
      for (int i = 0; i < len; i++) send_item(FUNC_ABSORB, 8'($urandom));
      send_item(FUNC_FINISH, 8'($urandom));
   endtask

   int unsigned sent;
   int unsigned len;

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty messages and a short message with extreme bytes
      send_item(FUNC_FINISH, 8'hff);
      send_item(FUNC_ABSORB, 8'h00);
      send_item(FUNC_ABSORB, 8'hff);
      send_item(FUNC_ABSORB, 8'h80);
      send_item(FUNC_FINISH, 8'h00);
      send_item(FUNC_FINISH, 8'h55);

      // Random messages over idling phases; lengths straddle 55/56/64 bytes
      sent = 0;
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
            default: begin send_idle_pct = 32; recv_stall_pct = 32; end
         endcase
         while (sent < (ph + 1) * 118) begin
            case ($urandom_range(3))
               0: len = $urandom_range(4);
               1: len = $urandom_range(54, 57);
               2: len = $urandom_range(62, 66);
               default: len = $urandom_range(20);
            endcase
            send_message(len);
            sent += len + 1;
         end
      end
      req_tvalid <= 1'b0;

      while (sb.pending_word.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (sb.errors == 0 && sb.pending_word.size() == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end
endmodule

>>> sha256_message_digest_unit.f
src/sha_pkg.sv
src/sha_datapath.sv
src/sha_control.sv
src/sha256_message_digest_unit.sv
tb/sv/testbench.sv
